// File: src/mro_pkg.sv
// ============================================================================
// mro_pkg: shared definitions for the maximal rectangle of ones unit
// Field widths, register map, reset values and the command and status words
// passed between the controller and the datapath.
// ============================================================================
package mro_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int AREA_W = 17;
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    localparam int ROW_WIDTH_W = 7;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 7'd64;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_ROW_WIDTH = 3'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch the incoming word
        logic cell_upd;     // update the column height and the column position
        logic sweep_start;  // begin the histogram sweep of a finished row
        logic sweep_rd;     // height memory is addressed by the sweep index
        logic pop;          // pop the stack top and form its area
        logic push;         // push the current column onto the stack
        logic load_top;     // refill the top register and fold the area into the best
        logic emit;         // load the result register and clear the matrix state
    } mro_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic row_end;
        logic last;
        logic sweep_done;
        logic pop_cond;
        logic out_free;
    } mro_status_t;

endpackage

// File: src/mro_if.sv
// ============================================================================
// mro_if: handshake channels of the maximal rectangle of ones unit
// One channel carries matrix cells in, the other carries results out.
// ============================================================================
interface mro_cell_if;
    logic valid;
    logic ready;
    logic cell_req;
    logic last_cell;

    modport source (output valid, output cell_req, output last_cell, input ready);
    modport sink (input valid, input cell_req, input last_cell, output ready);
endinterface

interface mro_result_if
    import mro_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [AREA_W-1:0] max_area;
    logic              malformed;

    modport source (output valid, output max_area, output malformed, input ready);
    modport sink (input valid, input max_area, input malformed, output ready);
endinterface

// File: src/mro_ctrl.sv
// ============================================================================
// mro_ctrl: controller of the maximal rectangle of ones unit
// Sequences cell updates, the stack sweep at each row end and result output.
// ============================================================================
module mro_ctrl
    import mro_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mro_status_t status,
    output mro_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CELL  = 6'b000010,
        S_FETCH = 6'b000100,
        S_CMP   = 6'b001000,
        S_LOAD  = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CELL;
                end
            end
            S_CELL:
            begin
                cmd.cell_upd = 1'b1;
                if (status.row_end)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = S_FETCH;
                end
                else if (status.last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                cmd.sweep_rd = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                cmd.sweep_rd = 1'b1;
                if (status.pop_cond)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_LOAD;
                end
                else if (!status.sweep_done)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_FETCH;
                end
                else if (status.last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOAD:
            begin
                cmd.sweep_rd = 1'b1;
                cmd.load_top = 1'b1;
                state_next   = S_CMP;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/mro_datapath.sv
// ============================================================================
// mro_datapath: datapath of the maximal rectangle of ones unit
// Column height memory, index stack memory, area multiplier, best-area
// tracking, the row width register and the result register.
// ============================================================================
module mro_datapath
    import mro_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mro_cmd_t              cmd,
    output mro_status_t           status,
    input  logic                  in_cell,
    input  logic                  in_last,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [AREA_W-1:0]     out_area,
    output logic                  out_malformed,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata
);

    localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int WW   = $clog2(MAX_COLS + 1);
    localparam int HW   = $clog2(MAX_ROWS + 1);
    localparam int SW   = $clog2(MAX_COLS + 2);
    localparam int PW   = HW + WW;
    localparam int SATW = (PW > AREA_W) ? PW : AREA_W;
    localparam int EW   = WW + ROW_WIDTH_W;

    localparam logic [EW-1:0]   MAXC_EXT = EW'(MAX_COLS);
    localparam logic [WW-1:0]   MAXC_W   = WW'(MAX_COLS);
    localparam logic [HW-1:0]   HMAX     = HW'(MAX_ROWS);
    localparam logic [SATW-1:0] AMAX_EXT = SATW'(AREA_MAX);

    // A stack entry holds the left edge of its rectangle and its height.
    typedef struct packed {
        logic [WW-1:0] left;
        logic [HW-1:0] h;
    } entry_t;

    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic                   cell_reg;
    logic                   last_reg;
    logic                   mal_reg;
    logic [CW-1:0]          col_pos_reg;
    logic [MAX_COLS-1:0]    hgt_vld_reg;
    logic [HW-1:0]          hgt_mem [MAX_COLS];
    logic [HW-1:0]          hgt_rd_reg;
    logic                   hgt_rd_vld_reg;
    entry_t                 stk_mem [MAX_COLS];
    entry_t                 stk_rd_reg;
    entry_t                 top_reg;
    logic [WW-1:0]          i_reg;
    logic [SW-1:0]          sd_reg;
    logic [WW-1:0]          pend_left_reg;
    logic [PW-1:0]          prod_reg;
    logic [AREA_W-1:0]      best_reg;
    logic                   out_valid_reg;
    logic [AREA_W-1:0]      out_area_reg;
    logic                   out_mal_reg;

    logic [EW-1:0]     rw_ext;
    logic [WW-1:0]     w_eff;
    logic [WW-1:0]     col_inc;
    logic              row_end;
    logic [CW-1:0]     hgt_addr;
    logic [HW-1:0]     old_h;
    logic [HW-1:0]     hgt_new;
    logic [HW-1:0]     cur_h;
    logic              sweep_done;
    logic [SW-1:0]     sd_m1;
    logic [SW-1:0]     sd_m2;
    logic [WW-1:0]     span;
    logic [SATW-1:0]   prod_ext;
    logic [AREA_W-1:0] area_cand;
    logic              cfg_wr;

    // Configuration register.
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ROW_WIDTH);
    assign prdata = (paddr == ADDR_ROW_WIDTH) ? APB_DATA_W'(row_width_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RST;
        end
        else if (cfg_wr)
        begin
            row_width_reg <= pwdata[ROW_WIDTH_W-1:0];
        end
    end

    // A width of zero acts as one, and a width past the column count is clamped.
    assign rw_ext = EW'(row_width_reg);

    always_comb
    begin
        if (rw_ext == '0)
        begin
            w_eff = WW'(1);
        end
        else if (rw_ext > MAXC_EXT)
        begin
            w_eff = MAXC_W;
        end
        else
        begin
            w_eff = rw_ext[WW-1:0];
        end
    end

    assign col_inc = WW'(col_pos_reg) + WW'(1);
    assign row_end = (col_inc >= w_eff);

    // Column height memory. Entries without a valid bit read as zero.
    assign hgt_addr = cmd.sweep_rd ? i_reg[CW-1:0] : col_pos_reg;
    assign old_h    = hgt_rd_vld_reg ? hgt_rd_reg : '0;

    always_comb
    begin
        if (!cell_reg)
        begin
            hgt_new = '0;
        end
        else if (old_h == HMAX)
        begin
            hgt_new = old_h;
        end
        else
        begin
            hgt_new = old_h + HW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        hgt_rd_reg     <= hgt_mem[hgt_addr];
        hgt_rd_vld_reg <= hgt_vld_reg[hgt_addr];
        if (cmd.cell_upd)
        begin
            hgt_mem[col_pos_reg] <= hgt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hgt_vld_reg <= '0;
        end
        else if (cmd.emit)
        begin
            hgt_vld_reg <= '0;
        end
        else if (cmd.cell_upd)
        begin
            hgt_vld_reg[col_pos_reg] <= 1'b1;
        end
    end

    // Incoming word and per-cell bookkeeping.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cell_reg <= in_cell;
            last_reg <= in_last;
        end
        if (cmd.cell_upd)
        begin
            mal_reg <= !row_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
        end
        else if (cmd.emit)
        begin
            col_pos_reg <= '0;
        end
        else if (cmd.cell_upd)
        begin
            col_pos_reg <= row_end ? '0 : col_inc[CW-1:0];
        end
    end

    // Sweep: the column whose index equals the row width, one past the last column,
    // acts as height zero and flushes the stack.
    assign sweep_done = (i_reg == w_eff);
    assign cur_h      = sweep_done ? '0 : old_h;
    assign sd_m1      = sd_reg - SW'(1);
    assign sd_m2      = sd_reg - SW'(2);
    assign span       = i_reg - top_reg.left;

    // The top entry lives in a register, the entries below it in memory.
    always_ff @(posedge clk)
    begin
        stk_rd_reg <= stk_mem[sd_m2[CW-1:0]];
        if (cmd.push && (sd_reg != '0))
        begin
            stk_mem[sd_m1[CW-1:0]] <= top_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_start)
        begin
            pend_left_reg <= '0;
        end
        else if (cmd.push)
        begin
            top_reg.left  <= pend_left_reg;
            top_reg.h     <= cur_h;
            pend_left_reg <= i_reg + WW'(1);
        end
        else if (cmd.pop)
        begin
            // A later push extends left to where the popped bar began.
            pend_left_reg <= top_reg.left;
            prod_reg      <= PW'(top_reg.h) * PW'(span);
        end
        else if (cmd.load_top && (sd_reg != '0))
        begin
            top_reg <= stk_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg  <= '0;
            sd_reg <= '0;
        end
        else if (cmd.sweep_start)
        begin
            i_reg  <= '0;
            sd_reg <= '0;
        end
        else if (cmd.push)
        begin
            i_reg  <= i_reg + WW'(1);
            sd_reg <= sd_reg + SW'(1);
        end
        else if (cmd.pop)
        begin
            sd_reg <= sd_m1;
        end
    end

    // Best area, saturated to the result width.
    assign prod_ext  = SATW'(prod_reg);
    assign area_cand = (prod_ext > AMAX_EXT) ? AREA_MAX : prod_ext[AREA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (cmd.emit)
        begin
            best_reg <= '0;
        end
        else if (cmd.load_top && (area_cand > best_reg))
        begin
            best_reg <= area_cand;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_area_reg <= best_reg;
            out_mal_reg  <= mal_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_area      = out_area_reg;
    assign out_malformed = out_mal_reg;

    assign status.row_end    = row_end;
    assign status.last       = last_reg;
    assign status.sweep_done = sweep_done;
    assign status.pop_cond   = (sd_reg != '0) && (top_reg.h >= cur_h);
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

// File: src/maximal_rectangle_of_ones_unit.sv
// A cell that does not end a row is captured in S_IDLE and applied in S_CELL;
// a row-ending cell then sweeps the height memory and the stack memory over the
// row width (S_FETCH and S_CMP per column, S_LOAD and S_CMP per pop, one port
// each). The word marked last then loads the result register in S_EMIT.
// Reset (asynchronous, active low) clears all heights at once through valid
// bits, sets the row width to 64 and leaves the stack memory unset.
// ============================================================================
// maximal_rectangle_of_ones_unit: largest all-ones rectangle of a cell stream
// Keeps column heights per row, sweeps a monotonic stack at each row end and
// reports the best area and a malformed flag on the last cell.
// ============================================================================
module maximal_rectangle_of_ones_unit
    import mro_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    mro_cell_if.sink              cells,
    mro_result_if.source          result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    mro_cmd_t    cmd;
    mro_status_t status;
    logic        in_ready;

    assign cells.ready = in_ready;
    assign pready      = 1'b1;

    mro_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cells.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mro_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_cell       (cells.cell_req),
        .in_last       (cells.last_cell),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .out_area      (result.max_area),
        .out_malformed (result.malformed),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata)
    );

endmodule
